// ===== sv/pde_pkg.sv =====
// ----------------------------------------------------------------------------
// pde_pkg
// Shared constants for the pixel difference error statistics block.
// ----------------------------------------------------------------------------
package pde_pkg;

  localparam int PIX_W      = 8;
  localparam int SUM_ABS_W  = 30;
  localparam int SUM_SQ_W   = 38;
  localparam int PEAK_NEG_W = 9;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_GAIN      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARK_THRESHOLD = 1'b1;

  localparam logic [PIX_W-1:0] GAIN_RESET   = 8'd10;
  localparam logic [PIX_W-1:0] THRESH_RESET = 8'd10;
  localparam logic [PIX_W-1:0] PIX_MAX      = 8'd255;

  localparam longint unsigned MAX_PIXELS = 64'd4194304;

  // saturation limits: pixel count times the largest term, capped at field width
  localparam longint unsigned ABS_RAW  = 64'd255 * MAX_PIXELS;
  localparam longint unsigned ABS_MASK = (64'd1 << SUM_ABS_W) - 64'd1;
  localparam longint unsigned SQ_RAW   = 64'd65025 * MAX_PIXELS;
  localparam longint unsigned SQ_MASK  = (64'd1 << SUM_SQ_W) - 64'd1;

  localparam logic [SUM_ABS_W-1:0] ABS_LIMIT =
    SUM_ABS_W'((ABS_RAW < ABS_MASK) ? ABS_RAW : ABS_MASK);
  localparam logic [SUM_SQ_W-1:0] SQ_LIMIT =
    SUM_SQ_W'((SQ_RAW < SQ_MASK) ? SQ_RAW : SQ_MASK);

endpackage

// ===== sv/pde_in_if.sv =====
// ----------------------------------------------------------------------------
// pde_in_if
// Pixel pair channel: reference and test gray with an end of frame mark.
// ----------------------------------------------------------------------------
interface pde_in_if;
  logic                      valid;
  logic                      ready;
  logic [pde_pkg::PIX_W-1:0] ref_pixel;
  logic [pde_pkg::PIX_W-1:0] test_pixel;
  logic                      frame_end;

  modport source (output valid, ref_pixel, test_pixel, frame_end, input ready);
  modport sink   (input valid, ref_pixel, test_pixel, frame_end, output ready);
endinterface

// ===== sv/pde_out_if.sv =====
// ----------------------------------------------------------------------------
// pde_out_if
// Result channel: heat and overlay pixels plus running frame statistics.
// ----------------------------------------------------------------------------
interface pde_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [pde_pkg::PIX_W-1:0]             heat_red;
  logic [pde_pkg::PIX_W-1:0]             heat_blue;
  logic [pde_pkg::PIX_W-1:0]             abs_diff;
  logic [pde_pkg::PIX_W-1:0]             overlay_gray;
  logic [pde_pkg::PIX_W-1:0]             overlay_red;
  logic [pde_pkg::SUM_ABS_W-1:0]         sum_abs;
  logic [pde_pkg::SUM_SQ_W-1:0]          sum_sq;
  logic [pde_pkg::PIX_W-1:0]             peak_pos;
  logic signed [pde_pkg::PEAK_NEG_W-1:0] peak_neg;
  logic                                  stats_final;

  modport source (output valid, heat_red, heat_blue, abs_diff, overlay_gray,
                  overlay_red, sum_abs, sum_sq, peak_pos, peak_neg, stats_final,
                  input ready);
  modport sink   (input valid, heat_red, heat_blue, abs_diff, overlay_gray,
                  overlay_red, sum_abs, sum_sq, peak_pos, peak_neg, stats_final,
                  output ready);
endinterface

// ===== sv/pixel_difference_error_stats.sv =====
// ----------------------------------------------------------------------------
// pixel_difference_error_stats
// Per pixel pair: heat map, absolute difference, threshold overlay and frame
// statistics (sum of absolute and squared differences, positive and negative
// peaks). Takes one pixel pair per clock while out_ch is not stalled; each
// result passes an input register and then a result register, with a single
// saturating add per sum between them. The statistics in a result include its
// own pixel and are cleared after the pixel marked frame_end. Configuration
// (gain, threshold) is written on cfg_we; the user must do so only while no
// pixel is in flight; the block does not enforce it. Reset values: 10 for both.
// ----------------------------------------------------------------------------
module pixel_difference_error_stats (
  input  logic                             clk,
  input  logic                             rst_n,
  pde_in_if.sink                           in_ch,
  pde_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [pde_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pde_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import pde_pkg::*;

  logic [PIX_W-1:0] gain_r, thresh_r;

  // input stage
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_ref_r, s1_test_r;
  logic             s1_last_r;

  // frame statistics; negative peak kept as a magnitude
  logic [SUM_ABS_W-1:0] abs_total_r, abs_total_nxt;
  logic [SUM_SQ_W-1:0]  sq_total_r, sq_total_nxt;
  logic [PIX_W-1:0]     pos_peak_r, pos_peak_nxt;
  logic [PIX_W-1:0]     neg_mag_r, neg_mag_nxt;

  // result register
  logic                        out_valid_r;
  logic [PIX_W-1:0]            heat_red_r, heat_blue_r, abs_diff_r;
  logic [PIX_W-1:0]            overlay_gray_r, overlay_red_r;
  logic [SUM_ABS_W-1:0]        sum_abs_r;
  logic [SUM_SQ_W-1:0]         sum_sq_r;
  logic [PIX_W-1:0]            peak_pos_r;
  logic signed [PEAK_NEG_W-1:0] peak_neg_r;
  logic                        stats_final_r;

  logic                 out_free, s1_adv, in_xfer;
  logic                 is_neg, is_pos;
  logic [PIX_W-1:0]     ad;
  logic [2*PIX_W-1:0]   heat_prod, sq_term;
  logic [SUM_ABS_W:0]   abs_sum;
  logic [SUM_SQ_W:0]    sq_sum;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    is_neg    = s1_ref_r < s1_test_r;
    is_pos    = s1_ref_r > s1_test_r;
    ad        = is_neg ? (s1_test_r - s1_ref_r) : (s1_ref_r - s1_test_r);
    heat_prod = (2*PIX_W)'(ad) * (2*PIX_W)'(gain_r);
    sq_term   = (2*PIX_W)'(ad) * (2*PIX_W)'(ad);

    abs_sum = {1'b0, abs_total_r} + (SUM_ABS_W + 1)'(ad);
    abs_total_nxt = (abs_sum > {1'b0, ABS_LIMIT}) ? ABS_LIMIT : abs_sum[SUM_ABS_W-1:0];

    sq_sum = {1'b0, sq_total_r} + (SUM_SQ_W + 1)'(sq_term);
    sq_total_nxt = (sq_sum > {1'b0, SQ_LIMIT}) ? SQ_LIMIT : sq_sum[SUM_SQ_W-1:0];

    pos_peak_nxt = (is_pos && ad > pos_peak_r) ? ad : pos_peak_r;
    neg_mag_nxt  = (is_neg && ad > neg_mag_r)  ? ad : neg_mag_r;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RESET;
      thresh_r <= THRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIFF_GAIN:      gain_r   <= cfg_wdata;
        CFG_MARK_THRESHOLD: thresh_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (out_free) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_ref_r  <= in_ch.ref_pixel;
      s1_test_r <= in_ch.test_pixel;
      s1_last_r <= in_ch.frame_end;
    end
  end

  // statistics, cleared after the last pixel of a frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abs_total_r <= '0;
      sq_total_r  <= '0;
      pos_peak_r  <= '0;
      neg_mag_r   <= '0;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        abs_total_r <= '0;
        sq_total_r  <= '0;
        pos_peak_r  <= '0;
        neg_mag_r   <= '0;
      end else begin
        abs_total_r <= abs_total_nxt;
        sq_total_r  <= sq_total_nxt;
        pos_peak_r  <= pos_peak_nxt;
        neg_mag_r   <= neg_mag_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      heat_red_r     <= is_pos ? heat_prod[PIX_W-1:0] : '0;
      heat_blue_r    <= is_neg ? heat_prod[PIX_W-1:0] : '0;
      abs_diff_r     <= ad;
      overlay_gray_r <= s1_ref_r;
      overlay_red_r  <= (ad >= thresh_r) ? PIX_MAX : s1_ref_r;
      sum_abs_r      <= abs_total_nxt;
      sum_sq_r       <= sq_total_nxt;
      peak_pos_r     <= pos_peak_nxt;
      peak_neg_r     <= PEAK_NEG_W'(0) - {1'b0, neg_mag_nxt};
      stats_final_r  <= s1_last_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.heat_red     = heat_red_r;
  assign out_ch.heat_blue    = heat_blue_r;
  assign out_ch.abs_diff     = abs_diff_r;
  assign out_ch.overlay_gray = overlay_gray_r;
  assign out_ch.overlay_red  = overlay_red_r;
  assign out_ch.sum_abs      = sum_abs_r;
  assign out_ch.sum_sq       = sum_sq_r;
  assign out_ch.peak_pos     = peak_pos_r;
  assign out_ch.peak_neg     = peak_neg_r;
  assign out_ch.stats_final  = stats_final_r;

endmodule

// ===== sv/pde_checker.sv =====
// ----------------------------------------------------------------------------
// pde_checker
// Port level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pde_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [pde_pkg::PIX_W-1:0]             heat_red,
  input logic [pde_pkg::PIX_W-1:0]             heat_blue,
  input logic [pde_pkg::PIX_W-1:0]             abs_diff,
  input logic [pde_pkg::PIX_W-1:0]             overlay_gray,
  input logic [pde_pkg::PIX_W-1:0]             overlay_red,
  input logic [pde_pkg::SUM_ABS_W-1:0]         sum_abs,
  input logic [pde_pkg::PIX_W-1:0]             peak_pos,
  input logic                                  stats_final
);
  import pde_pkg::*;

  logic out_xfer;
  assign out_xfer = out_valid && out_ready;

  // a stalled result stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // only one heat channel can be lit
  a_heat_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (heat_red == '0 || heat_blue == '0))
    else $error("heat red and blue both set");

  // overlay red is either the mark or the reference gray
  a_overlay: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (overlay_red == PIX_MAX || overlay_red == overlay_gray))
    else $error("overlay red neither marked nor gray");

  // positive peak covers the current positive difference
  a_peak_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && heat_red != '0 |-> peak_pos >= abs_diff)
    else $error("positive peak below current difference");

  // within a frame, back to back transfers never shrink the sum
  a_sum_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !stats_final ##1 out_xfer |-> sum_abs >= $past(sum_abs))
    else $error("absolute sum decreased within a frame");

endmodule

bind pixel_difference_error_stats pde_checker u_pde_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .heat_red     (out_ch.heat_red),
  .heat_blue    (out_ch.heat_blue),
  .abs_diff     (out_ch.abs_diff),
  .overlay_gray (out_ch.overlay_gray),
  .overlay_red  (out_ch.overlay_red),
  .sum_abs      (out_ch.sum_abs),
  .peak_pos     (out_ch.peak_pos),
  .stats_final  (out_ch.stats_final)
);
